@@ rtl/offset_table_delta_decoder_defines.svh @@
// Assertion macros used by the offset table delta decoder checker.
`ifndef OFFSET_TABLE_DELTA_DECODER_DEFINES_SVH
`define OFFSET_TABLE_DELTA_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTDD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("offset table decoder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OTDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("offset table decoder: assertion failed");

// Next-cycle implication that is also checked across reset.
`define OTDD_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("offset table decoder: assertion failed");

`endif

@@ rtl/otdd_pkg.sv @@
// Types and codes shared by the offset table delta decoder modules.
package otdd_pkg;

    localparam int PosWidth   = 32;
    localparam int DeltaWidth = 30;
    localparam int ByteWidth  = 8;

    // Result status codes, carried on m_tuser.
    localparam logic [1:0] STATUS_OFFSET    = 2'd0;
    localparam logic [1:0] STATUS_TERMINATE = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Code kinds held in the top two bits of a lead byte.
    localparam logic [1:0] KIND_END   = 2'b00;
    localparam logic [1:0] KIND_SHORT = 2'b01;
    localparam logic [1:0] KIND_MID   = 2'b10;
    localparam logic [1:0] KIND_LONG  = 2'b11;

    typedef struct packed {
        logic [PosWidth-1:0]   position;
        logic [DeltaWidth-1:0] delta;
        logic [1:0]            pending;
        logic                  start;
        logic                  stopped;
    } otdd_state_t;

    typedef struct packed {
        logic                valid;
        logic [PosWidth-1:0] position;
        logic [1:0]          status;
        logic                last;
    } otdd_result_t;

endpackage

@@ rtl/otdd_decode.sv @@
// Next-state and result logic for one table byte of the offset table decoder.
module otdd_decode import otdd_pkg::*; (
    input  otdd_state_t          state,
    input  logic [PosWidth-1:0]  base_address,
    input  logic [ByteWidth-1:0] table_byte,
    input  logic                 table_end,
    output otdd_state_t          state_next,
    output otdd_result_t         result
);

    logic [PosWidth-1:0]   pos_cur;
    logic [PosWidth-1:0]   pos_sum;
    logic [DeltaWidth-1:0] delta_new;
    logic [1:0]            pend_new;
    logic                  complete;
    logic                  terminate;

    // The position is loaded from the base on the first byte of a table.
    assign pos_cur = state.start ? base_address : state.position;
    assign pos_sum = pos_cur + {delta_new, 2'b00};

    always_comb begin
        delta_new = state.delta;
        pend_new  = state.pending;
        complete  = 1'b0;
        terminate = 1'b0;
        if (state.pending == 2'd0) begin
            delta_new = {{(DeltaWidth-6){1'b0}}, table_byte[5:0]};
            case (table_byte[7:6])
                KIND_END: begin
                    terminate = 1'b1;
                end
                KIND_SHORT: begin
                    complete = 1'b1;
                end
                KIND_MID: begin
                    pend_new = 2'd1;
                end
                KIND_LONG: begin
                    pend_new = 2'd3;
                end
                default: begin
                    pend_new = 2'd0;
                end
            endcase
        end else begin
            delta_new = {state.delta[DeltaWidth-ByteWidth-1:0], table_byte};
            pend_new  = state.pending - 2'd1;
            complete  = (state.pending == 2'd1);
        end
    end

    always_comb begin
        result           = '0;
        state_next       = state;
        state_next.start = 1'b0;
        state_next.position = pos_cur;
        if (state.stopped) begin
            // Bytes after a terminator are skipped until the table ends.
        end else if (terminate) begin
            result.valid        = 1'b1;
            result.status       = STATUS_TERMINATE;
            result.last         = 1'b1;
            state_next.delta    = delta_new;
            state_next.stopped  = 1'b1;
        end else if (complete) begin
            result.valid        = 1'b1;
            result.position     = pos_sum;
            result.status       = STATUS_OFFSET;
            result.last         = table_end;
            state_next.position = pos_sum;
            state_next.delta    = '0;
            state_next.pending  = pend_new;
        end else begin
            state_next.delta    = delta_new;
            state_next.pending  = pend_new;
            if (table_end) begin
                result.valid  = 1'b1;
                result.status = STATUS_TRUNCATED;
                result.last   = 1'b1;
            end
        end
        if (table_end) begin
            state_next          = '0;
            state_next.start    = 1'b1;
        end
    end

endmodule

@@ rtl/offset_table_delta_decoder.sv @@
// Top level of the offset table delta decoder with its output register.
// A result is registered and appears on the master side in the cycle after its byte is accepted.
// Throughput: one table byte per cycle while m_tready keeps up; the single-stage add of delta * 4 sets the path.
// s_tready falls only while a held result waits on m_tready, so stalls cost no bubbles.
// Reset (aresetn low, synchronous) clears base_address and the output valid and returns decode state to table start.
module offset_table_delta_decoder import otdd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: base_address is written whenever cfg_wr_en is high.
    input  logic                 cfg_wr_en,
    input  logic [PosWidth-1:0]  cfg_wr_data,
    // Input stream of table bytes.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteWidth-1:0] s_tdata,   // [7:0] table_byte
    input  logic                 s_tlast,   // table_end
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PosWidth-1:0]  m_tdata,   // [31:0] fix_position
    output logic [1:0]           m_tuser,   // [1:0] status
    output logic                 m_tlast    // last
);

    otdd_state_t         state_reg;
    otdd_state_t         state_next;
    otdd_result_t        result;
    logic [PosWidth-1:0] base_reg;
    logic                out_valid_reg;
    logic [PosWidth-1:0] out_pos_reg;
    logic [1:0]          out_status_reg;
    logic                out_last_reg;
    logic                in_accept;

    // A new request is taken whenever the output register is empty or is
    // being drained in this same cycle. That keeps the stream moving at one
    // byte per clock while the sink keeps up.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // The decode logic looks at the current byte and the stored decode state
    // and produces both the next state and at most one result.
    otdd_decode u_decode (
        .state        (state_reg),
        .base_address (base_reg),
        .table_byte   (s_tdata),
        .table_end    (s_tlast),
        .state_next   (state_next),
        .result       (result)
    );

    // Base address register. Software must write it only between tables; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    // Decode state advances once per accepted byte. The start flag comes
    // out of reset set, so the first byte loads the base address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{position: '0, delta: '0, pending: 2'd0,
                           start: 1'b1, stopped: 1'b0};
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register. It loads on every accepted byte; a byte that gives no
    // result simply leaves it empty once the previous result has been taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_pos_reg    <= result.position;
            out_status_reg <= result.status;
            out_last_reg   <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/otdd_checker.sv @@
// Port-level checker for the offset table delta decoder, bound to the top level.
`include "offset_table_delta_decoder_defines.svh"

module otdd_checker import otdd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [PosWidth-1:0]  m_tdata,
    input logic [1:0]           m_tuser,
    input logic                 m_tlast
);

    // A stalled result keeps its contents.
    `OTDD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

    // Terminator and truncation results carry no position and close the table.
    `OTDD_ASSERT_NOW(a_status_zero, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OFFSET), (m_tdata == '0) && m_tlast)

    // No result shows up without a byte having been accepted.
    `OTDD_ASSERT_NEXT(a_no_spurious, aclk, aresetn, !m_tvalid && !(s_tvalid && s_tready), !m_tvalid)

    // The output is empty in the cycle after reset.
    `OTDD_ASSERT_RESET(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind offset_table_delta_decoder otdd_checker u_otdd_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for the offset table delta decoder: directed and random tables.
`timescale 1ns / 100ps

module tb;
    import otdd_pkg::*;

    // The run ends as failed when this many cycles pass without any request
    // being accepted on either stream and without a register write.
    localparam int STALL_LIMIT = 2000;

    // One expected relocation result, in the order that the block emits them.
    typedef struct packed {
        logic [PosWidth-1:0] position;
        logic [1:0]          status;
        logic                is_last;
    } fix_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [PosWidth-1:0]  cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ByteWidth-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PosWidth-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    offset_table_delta_decoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Results that the decoder still owes us, oldest first.
    fix_result_t expected_fixes[$];

    // Our own copy of the decoder state. It is advanced at the clock edge at
    // which the block accepts a table byte.
    logic [PosWidth-1:0]   base_reg;
    logic [PosWidth-1:0]   run_pos;
    logic [DeltaWidth-1:0] delta_acc;
    logic [1:0]            bytes_owed;
    logic                  at_table_start;
    logic                  skipping;

    int  mismatches;
    int  decoded_bytes;
    int  results_checked;
    int  tables_sent;
    int  idle_cycles;
    int  stall_left;
    bit  no_gaps;

    always #5 aclk = ~aclk;

    // Gap lengths for both streams: usually none, often short, and
    // now and then a long pause. A test can switch the gaps off entirely.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // A table ends on the byte that carries table_end; everything returns
    // to its reset values so that the following byte opens a new table.
    task automatic clear_table();
        run_pos        = '0;
        delta_acc      = '0;
        bytes_owed     = 2'd0;
        at_table_start = 1'b1;
        skipping       = 1'b0;
    endtask

    task automatic push_fix(input logic [PosWidth-1:0] pos, input logic [1:0] status,
                            input logic is_last);
        fix_result_t r;
        r.position = pos;
        r.status   = status;
        r.is_last  = is_last;
        expected_fixes.push_back(r);
    endtask

    // Decodes one accepted table byte and queues the result it causes, if any.
    task automatic decode_table_byte(input logic [ByteWidth-1:0] b, input logic fin);
        logic code_done;
        code_done = 1'b0;
        if (at_table_start) begin
            // The base register is only sampled on the first byte of a table.
            run_pos        = base_reg;
            at_table_start = 1'b0;
        end
        if (skipping) begin
            // After a terminator the rest of the table is dropped silently.
            if (fin) begin
                clear_table();
            end
        end else if (bytes_owed == 2'd0 && b[7:6] == KIND_END) begin
            decoded_bytes++;
            push_fix('0, STATUS_TERMINATE, 1'b1);
            skipping = 1'b1;
            if (fin) begin
                clear_table();
            end
        end else begin
            decoded_bytes++;
            if (bytes_owed == 2'd0) begin
                // The low six bits of the lead byte are the top of the delta.
                delta_acc = {24'd0, b[5:0]};
                if (b[7:6] == KIND_SHORT) begin
                    code_done = 1'b1;
                end else if (b[7:6] == KIND_MID) begin
                    bytes_owed = 2'd1;
                end else begin
                    bytes_owed = 2'd3;
                end
            end else begin
                delta_acc  = {delta_acc[DeltaWidth-9:0], b};
                bytes_owed = bytes_owed - 2'd1;
                code_done  = (bytes_owed == 2'd0);
            end
            if (code_done) begin
                // The delta counts words, so the byte position moves by four
                // times the delta and wraps at 32 bits.
                run_pos   = run_pos + {delta_acc, 2'b00};
                delta_acc = '0;
                push_fix(run_pos, STATUS_OFFSET, fin);
            end else if (fin) begin
                // The table stopped in the middle of a code.
                push_fix('0, STATUS_TRUNCATED, 1'b1);
            end
            if (fin) begin
                clear_table();
            end
        end
    endtask

    // Offers one table byte after a random gap and holds the request until the
    // decoder takes it. The valid stays high afterwards, so back-to-back
    // requests never lower and raise it within one time step.
    task automatic send_table_byte(input logic [ByteWidth-1:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        decode_table_byte(b, fin);
        if (fin) begin
            tables_sent++;
        end
    endtask

    task automatic send_table(input logic [ByteWidth-1:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_table_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Drops the request and waits until every owed result has come back.
    // The extra cycles cover a byte that was still in flight with no result.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_fixes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_base(input logic [PosWidth-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        base_reg = value;
    endtask

    // Builds a random table. Most are well formed: a run of codes of every
    // length, closed by a terminator (with or without trailing junk), by the
    // last code itself, or by a code that is cut short. The rest are noise.
    function automatic void build_random_table(ref logic [ByteWidth-1:0] bytes[$]);
        int n_codes;
        int ending;
        logic [1:0] kind;
        bytes = {};
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
            return;
        end
        n_codes = $urandom_range(0, 10);
        repeat (n_codes) begin
            kind = 2'($urandom_range(1, 3));
            bytes.push_back({kind, 6'($urandom)});
            if (kind == KIND_MID) begin
                bytes.push_back(8'($urandom));
            end else if (kind == KIND_LONG) begin
                repeat (3) bytes.push_back(8'($urandom));
            end
        end
        ending = $urandom_range(0, 99);
        if (ending < 50 || n_codes == 0) begin
            bytes.push_back({KIND_END, 6'($urandom)});
            repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
        end else if (ending >= 80) begin
            kind = 2'($urandom_range(2, 3));
            bytes.push_back({kind, 6'($urandom)});
            if (kind == KIND_LONG) begin
                repeat ($urandom_range(0, 2)) bytes.push_back(8'($urandom));
            end
        end
    endfunction

    // Every code length at its largest delta, the short and mid codes at their smallest,
    // a terminator with trailing bytes, a code that completes on the final byte, and
    // tables cut off after a lead byte and in the middle of a long code.
    task automatic test_code_forms();
        set_base(32'h0001_0000);
        send_table('{8'h40, 8'h7F, 8'h80, 8'h00, 8'hBF, 8'hFF,
                     8'hC0, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'hFF});
        send_table('{8'h41});
        send_table('{8'hC1, 8'h22});
        send_table('{8'h00});
        send_table('{8'h80});
    endtask

    // The position wraps past the top of the address space.
    task automatic test_position_wrap();
        set_base(32'hFFFF_FFFF);
        send_table('{8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    endtask

    // Random tables in several phases, each with its own base address.
    task automatic test_random_tables();
        logic [ByteWidth-1:0] bytes[$];
        logic [PosWidth-1:0]  bases[5];
        int goal;
        bases = '{32'($urandom), 32'h0, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'($urandom)};
        foreach (bases[p]) begin
            set_base(bases[p]);
            goal = decoded_bytes + 160;
            while (decoded_bytes < goal) begin
                build_random_table(bytes);
                send_table(bytes);
            end
        end
    endtask

    // Full rate on both sides, with no gaps and no stalls.
    task automatic test_back_to_back();
        logic [ByteWidth-1:0] bytes[$];
        int goal;
        no_gaps = 1'b1;
        goal = decoded_bytes + 60;
        while (decoded_bytes < goal) begin
            build_random_table(bytes);
            send_table(bytes);
        end
        no_gaps = 1'b0;
    endtask

    // The sender stops in the middle of tables and in the middle of codes
    // until the result side has fully drained, then carries on.
    task automatic test_paused_sender();
        logic [ByteWidth-1:0] bytes[$];
        repeat (6) begin
            build_random_table(bytes);
            for (int i = 0; i < bytes.size(); i++) begin
                if (i == bytes.size() / 2) begin
                    settle();
                end
                send_table_byte(bytes[i], i == bytes.size() - 1);
            end
        end
    endtask

    // The result side stalls at random, with the same mix of gap lengths.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin
        fix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fixes.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: position %h status %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_fixes.pop_front();
                results_checked++;
                if (m_tdata !== want.position) begin
                    mismatches++;
                    $display("%0t: fix_position expected %h got %h",
                             $time, want.position, m_tdata);
                end
                if (m_tuser !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
                end
                if (m_tlast !== want.is_last) begin
                    mismatches++;
                    $display("%0t: last expected %0b got %0b", $time, want.is_last, m_tlast);
                end
            end
        end
    end

    // Watchdog: a run that stops making progress is a failure.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results still owed",
                     $time, STALL_LIMIT, expected_fixes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        stall_left      = 0;
        no_gaps         = 1'b0;
        mismatches      = 0;
        decoded_bytes   = 0;
        results_checked = 0;
        tables_sent     = 0;
        idle_cycles     = 0;
        base_reg        = '0;
        clear_table();

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_code_forms();
        test_position_wrap();
        test_random_tables();
        test_back_to_back();
        test_paused_sender();
        settle();

        if (expected_fixes.size() != 0) begin
            mismatches++;
        end
        $display("Sent %0d tables (%0d decoded bytes) under seven base address settings;",
                 tables_sent, decoded_bytes);
        $display("checked %0d results with random gaps, stalls and drained pauses.",
                 results_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/otdd_pkg.sv
rtl/otdd_decode.sv
rtl/offset_table_delta_decoder.sv
rtl/otdd_checker.sv
bench/tb.sv
